/* rtl/core/websocket_frame_deframe_unmask_defines.svh */
// Assertion macros for the websocket deframer.
`ifndef WEBSOCKET_FRAME_DEFRAME_UNMASK_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAME_UNMASK_DEFINES_SVH

// same-cycle implication
`define WSDU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("websocket deframer: same-cycle check failed");

// next-cycle implication
`define WSDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("websocket deframer: next-cycle check failed");

`endif

/* rtl/core/wsdu_pkg.sv */
// Shared types and constants for the websocket deframer.
package wsdu_pkg;

    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CLOSE   = 2'd1,
        KIND_EMPTY   = 2'd2
    } wsdu_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       read_start;
    } wsdu_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
        logic [3:0] frame_opcode;
        logic       frame_fin;
    } wsdu_out_t;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic [1:0] kind;
        logic       last;
        logic [3:0] frame_opcode;
        logic       frame_fin;
    } wsdu_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wsdu_qstat_t;

endpackage

/* rtl/core/wsdu_parser.sv */
// Front end: header parser, length and mask capture, emits per-beat commands.
module wsdu_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_take,
    input  wsdu_pkg::wsdu_in_t in_data,
    output logic               cmd_push,
    output wsdu_pkg::wsdu_cmd_t cmd_data
);
    import wsdu_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_DATA,
        PH_CLOSED
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [63:0] rem_reg, rem_next;
    logic [3:0]  ext_reg, ext_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  kidx_reg, kidx_next;
    logic [3:0]  opc_reg, opc_next;
    logic        fin_reg, fin_next;
    logic [7:0]  b;

    assign b = in_data.data_byte;

    always_comb begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        ext_next   = ext_reg;
        key_next   = key_reg;
        kidx_next  = kidx_reg;
        opc_next   = opc_reg;
        fin_next   = fin_reg;
        cmd_push   = 1'b0;
        cmd_data   = '0;
        phase_cur  = in_data.read_start ? PH_HDR0 : phase_reg;
        if (in_take) begin
            unique case (phase_cur)
                PH_HDR0: begin
                    fin_next  = b[7];
                    opc_next  = b[3:0];
                    rem_next  = '0;
                    ext_next  = '0;
                    kidx_next = '0;
                    if (b[3:0] == OPC_CLOSE) begin
                        phase_next    = PH_CLOSED;
                        cmd_push      = 1'b1;
                        cmd_data.kind = KIND_CLOSE;
                        cmd_data.last = 1'b1;
                    end else begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1: begin
                    kidx_next = '0;
                    if (b[6:0] == 7'd126) begin
                        rem_next   = '0;
                        ext_next   = 4'd2;
                        phase_next = PH_EXT;
                    end else if (b[6:0] == 7'd127) begin
                        rem_next   = '0;
                        ext_next   = 4'd8;
                        phase_next = PH_EXT;
                    end else begin
                        rem_next   = {57'd0, b[6:0]};
                        phase_next = PH_MASK;
                    end
                end
                PH_EXT: begin
                    rem_next = {rem_reg[55:0], b};
                    ext_next = ext_reg - 4'd1;
                    if (ext_reg == 4'd1) begin
                        phase_next = PH_MASK;
                    end
                end
                PH_MASK: begin
                    key_next  = {key_reg[23:0], b};
                    kidx_next = kidx_reg + 2'd1;
                    if (kidx_reg == 2'd3) begin
                        if (rem_reg == 64'd0) begin
                            phase_next    = PH_HDR0;
                            cmd_push      = 1'b1;
                            cmd_data.kind = KIND_EMPTY;
                            cmd_data.last = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    rem_next          = rem_reg - 64'd1;
                    kidx_next         = kidx_reg + 2'd1;
                    cmd_push          = 1'b1;
                    cmd_data.kind     = KIND_PAYLOAD;
                    cmd_data.raw_byte = b;
                    cmd_data.key_byte = key_reg[{~kidx_reg, 3'b000} +: 8];
                    cmd_data.last     = (rem_reg == 64'd1);
                    if (rem_reg == 64'd1) begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_CLOSED: begin
                    phase_next = PH_CLOSED;
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
        cmd_data.frame_opcode = opc_next;
        cmd_data.frame_fin    = fin_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR0;
            rem_reg   <= '0;
            ext_reg   <= '0;
            key_reg   <= '0;
            kidx_reg  <= '0;
            opc_reg   <= '0;
            fin_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            ext_reg   <= ext_next;
            key_reg   <= key_next;
            kidx_reg  <= kidx_next;
            opc_reg   <= opc_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

/* rtl/core/wsdu_fifo.sv */
// Short command queue between parser and output stage.
module wsdu_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  wsdu_pkg::wsdu_cmd_t   push_data,
    input  logic                  pop,
    output wsdu_pkg::wsdu_cmd_t   pop_data,
    output wsdu_pkg::wsdu_qstat_t stat
);
    import wsdu_pkg::*;

    wsdu_cmd_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign pop_data   = q_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    // depth is a power of two, pointers wrap naturally
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/core/wsdu_out.sv */
// Back end: unmask and result register on the m_ channel.
module wsdu_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wsdu_pkg::wsdu_cmd_t   cmd_data,
    input  wsdu_pkg::wsdu_qstat_t q_stat,
    output logic                  cmd_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wsdu_pkg::wsdu_out_t   m_data
);
    import wsdu_pkg::*;

    logic      valid_reg;
    wsdu_out_t data_reg, data_next;

    assign cmd_pop = !q_stat.empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        data_next.out_byte     = cmd_data.raw_byte ^ cmd_data.key_byte;
        data_next.kind         = cmd_data.kind;
        data_next.last         = cmd_data.last;
        data_next.frame_opcode = cmd_data.frame_opcode;
        data_next.frame_fin    = cmd_data.frame_fin;
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

/* rtl/core/websocket_frame_deframe_unmask.sv */
// Top level of the websocket client-frame deframer and unmasker.
//
// s_ channel: one raw stream byte per beat plus read_start, which forces the
// byte to be parsed as the first header byte of a new frame.
// m_ channel: one result per payload byte (unmasked, last flagged), one close
// result per close header, one empty-frame result per zero-length frame.
// Header, extended length and mask-key bytes produce no result.
// Throughput: one input beat per cycle while the queue is not full, limited by the byte-wide parser.
// Path: the parser writes each result into a four-entry queue, from which it
// moves to the output register that drives m_.
// When m_ready is low the queue absorbs up to four results; s_ready drops
// only while the queue is full, and the parser stalls with it.
// Reset (aresetn low, synchronous) returns the parser to expecting header
// byte 0, clears the length, key and frame fields, and empties the queue.
// After a close header, bytes are taken and dropped until read_start.
`include "websocket_frame_deframe_unmask_defines.svh"

module websocket_frame_deframe_unmask (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wsdu_pkg::wsdu_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wsdu_pkg::wsdu_out_t m_data
);
    import wsdu_pkg::*;

    logic        in_take;
    logic        q_push, q_pop;
    wsdu_cmd_t   q_in, q_out;
    wsdu_qstat_t q_stat;

    assign s_ready = !q_stat.full;
    assign in_take = s_valid && s_ready;

    wsdu_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_take  (in_take),
        .in_data  (s_data),
        .cmd_push (q_push),
        .cmd_data (q_in)
    );

    wsdu_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    wsdu_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_data (q_out),
        .q_stat   (q_stat),
        .cmd_pop  (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `WSDU_ASSERT_IMPL(a_no_overflow, aclk, aresetn, q_push, !q_stat.full)
    `WSDU_ASSERT_IMPL(a_no_underflow, aclk, aresetn, q_pop, !q_stat.empty)
    `WSDU_ASSERT_NEXT(a_push_fills, aclk, aresetn, q_push, !q_stat.empty)
    `WSDU_ASSERT_IMPL(a_ctrl_result, aclk, aresetn, m_valid && (m_data.kind != KIND_PAYLOAD), m_data.last && (m_data.out_byte == 8'd0))

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the websocket client-frame deframer and unmasker.
`timescale 1ns / 100ps

module tb_top;
    import wsdu_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;

    typedef enum logic [2:0] {
        AWAIT_HDR0,
        AWAIT_HDR1,
        AWAIT_EXT,
        AWAIT_KEY,
        AWAIT_DATA,
        DISCARD
    } parse_phase_t;

    typedef enum int {
        LEN_SHORT,
        LEN_16,
        LEN_64
    } len_form_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    wsdu_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    wsdu_out_t m_data;

    websocket_frame_deframe_unmask dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    wsdu_in_t  rx_stream[$];
    wsdu_out_t frame_results_due[$];

    // parser copy
    parse_phase_t rx_phase = AWAIT_HDR0;
    logic [63:0]  rx_remaining = '0;
    logic [3:0]   rx_ext_left = '0;
    logic [31:0]  rx_key = '0;
    logic [1:0]   rx_key_idx = '0;
    logic [3:0]   rx_opcode = '0;
    logic         rx_fin = 1'b0;

    bit          resync_needed = 1'b0;
    bit          s_taken = 1'b0;
    bit          m_taken = 1'b0;
    bit          s_burst = 1'b0;
    bit          m_burst = 1'b0;
    int unsigned s_gap = 0;
    int unsigned m_stall = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_err = 0;
    int unsigned n_beats = 0;
    int unsigned n_frames = 0;
    int unsigned n_payload = 0;
    int unsigned n_close = 0;
    int unsigned n_empty = 0;

    function automatic int unsigned pick_wait(input bit burst);
        if (burst) begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic wsdu_out_t frame_result(input logic [7:0] b, input logic [1:0] k,
                                               input logic lst);
        wsdu_out_t r;
        r.out_byte     = b;
        r.kind         = k;
        r.last         = lst;
        r.frame_opcode = rx_opcode;
        r.frame_fin    = rx_fin;
        return r;
    endfunction

    task automatic deframe_byte(input wsdu_in_t beat);
        parse_phase_t p;
        logic [7:0]   kb;
        logic         lst;
        p = beat.read_start ? AWAIT_HDR0 : rx_phase;
        case (p)
            AWAIT_HDR0: begin
                rx_fin       = beat.data_byte[7];
                rx_opcode    = beat.data_byte[3:0];
                rx_remaining = '0;
                rx_ext_left  = '0;
                rx_key_idx   = '0;
                if (rx_opcode == OPC_CLOSE) begin
                    rx_phase = DISCARD;
                    frame_results_due.push_back(frame_result(8'h00, KIND_CLOSE, 1'b1));
                end else begin
                    rx_phase = AWAIT_HDR1;
                end
            end
            AWAIT_HDR1: begin
                rx_key_idx = '0;
                if (beat.data_byte[6:0] == 7'd126) begin
                    rx_remaining = '0;
                    rx_ext_left  = 4'd2;
                    rx_phase     = AWAIT_EXT;
                end else if (beat.data_byte[6:0] == 7'd127) begin
                    rx_remaining = '0;
                    rx_ext_left  = 4'd8;
                    rx_phase     = AWAIT_EXT;
                end else begin
                    rx_remaining = {57'd0, beat.data_byte[6:0]};
                    rx_phase     = AWAIT_KEY;
                end
            end
            AWAIT_EXT: begin
                rx_remaining = {rx_remaining[55:0], beat.data_byte};
                rx_ext_left  = rx_ext_left - 4'd1;
                if (rx_ext_left == 4'd0) begin
                    rx_phase = AWAIT_KEY;
                end
            end
            AWAIT_KEY: begin
                rx_key     = {rx_key[23:0], beat.data_byte};
                rx_key_idx = rx_key_idx + 2'd1;
                if (rx_key_idx == 2'd0) begin
                    if (rx_remaining == 64'd0) begin
                        rx_phase = AWAIT_HDR0;
                        frame_results_due.push_back(frame_result(8'h00, KIND_EMPTY, 1'b1));
                    end else begin
                        rx_phase = AWAIT_DATA;
                    end
                end
            end
            AWAIT_DATA: begin
                kb           = rx_key[8 * (3 - rx_key_idx) +: 8];
                rx_remaining = rx_remaining - 64'd1;
                rx_key_idx   = rx_key_idx + 2'd1;
                lst          = (rx_remaining == 64'd0);
                if (lst) begin
                    rx_phase = AWAIT_HDR0;
                end
                frame_results_due.push_back(
                    frame_result(beat.data_byte ^ kb, KIND_PAYLOAD, lst));
            end
            default: begin
                rx_phase = DISCARD;
            end
        endcase
    endtask

    task automatic push_beat(input logic [7:0] b, input logic rs);
        wsdu_in_t t;
        t.data_byte  = b;
        t.read_start = rs;
        rx_stream.push_back(t);
    endtask

    // cap limits the payload beats sent; a shorter frame is cut off by the next read start
    task automatic add_frame(input bit rs, input bit fin, input logic [3:0] opc,
                             input len_form_t form, input logic [63:0] len,
                             input logic [63:0] cap, input bit extremes);
        logic [7:0]  hdr;
        logic [63:0] n;
        logic [63:0] j;
        int          i;
        hdr      = 8'($urandom_range(0, 255));
        hdr[7]   = fin;
        hdr[3:0] = opc;
        push_beat(hdr, rs | resync_needed);
        resync_needed = 1'b0;
        n_frames++;
        if (opc == OPC_CLOSE) begin
            repeat ($urandom_range(0, 4)) push_beat(8'($urandom_range(0, 255)), 1'b0);
            resync_needed = 1'b1;
        end else begin
            hdr = 8'($urandom_range(0, 255));
            case (form)
                LEN_SHORT: hdr[6:0] = len[6:0];
                LEN_16:    hdr[6:0] = 7'd126;
                default:   hdr[6:0] = 7'd127;
            endcase
            push_beat(hdr, 1'b0);
            if (form == LEN_16) begin
                for (i = 1; i >= 0; i--) push_beat(len[8 * i +: 8], 1'b0);
            end else if (form == LEN_64) begin
                for (i = 7; i >= 0; i--) push_beat(len[8 * i +: 8], 1'b0);
            end
            for (i = 0; i < 4; i++) begin
                if (extremes) begin
                    push_beat((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0);
                end else begin
                    push_beat(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            n = (len < cap) ? len : cap;
            for (j = 0; j < n; j++) begin
                if (extremes) begin
                    push_beat(j[1] ? 8'hFF : 8'h00, 1'b0);
                end else begin
                    push_beat(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            if (n < len) begin
                resync_needed = 1'b1;
            end
        end
    endtask

    always @(negedge aclk) begin : beat_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end else if (s_valid && !s_taken) begin
            s_valid <= 1'b1;
        end else if (s_gap != 0) begin
            s_valid <= 1'b0;
            s_gap   <= s_gap - 1;
        end else if (rx_stream.size() != 0) begin
            s_data  <= rx_stream.pop_front();
            s_valid <= 1'b1;
            s_gap   <= pick_wait(s_burst);
            if ($urandom_range(0, 31) == 0) begin
                s_burst <= !s_burst;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin : result_ready
        int unsigned w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_stall <= 0;
        end else if (m_taken) begin
            w = pick_wait(m_burst);
            m_ready <= (w == 0);
            m_stall <= (w == 0) ? 0 : w - 1;
            if ($urandom_range(0, 31) == 0) begin
                m_burst <= !m_burst;
            end
        end else if (m_stall != 0) begin
            m_ready <= 1'b0;
            m_stall <= m_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        wsdu_out_t got;
        wsdu_out_t want;
        if (!aresetn) begin
            s_taken     <= 1'b0;
            m_taken     <= 1'b0;
            idle_cycles <= 0;
        end else begin
            s_taken     <= s_valid && s_ready;
            m_taken     <= m_valid && m_ready;
            idle_cycles <= ((s_valid && s_ready) || (m_valid && m_ready)) ? 0 : idle_cycles + 1;
            if (s_valid && s_ready) begin
                deframe_byte(s_data);
                n_beats++;
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (frame_results_due.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected beat: byte %h kind %0d last %0b opc %h fin %0b",
                             $time, got.out_byte, got.kind, got.last,
                             got.frame_opcode, got.frame_fin);
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                        got.last !== want.last || got.frame_opcode !== want.frame_opcode ||
                        got.frame_fin !== want.frame_fin) begin
                        n_err++;
                        $display("%0t: mismatch exp byte %h kind %0d last %0b opc %h fin %0b",
                                 $time, want.out_byte, want.kind, want.last,
                                 want.frame_opcode, want.frame_fin);
                        $display("%0t:          got byte %h kind %0d last %0b opc %h fin %0b",
                                 $time, got.out_byte, got.kind, got.last,
                                 got.frame_opcode, got.frame_fin);
                    end
                    if (want.kind == KIND_PAYLOAD) begin
                        n_payload++;
                    end else if (want.kind == KIND_CLOSE) begin
                        n_close++;
                    end else begin
                        n_empty++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("[websocket_frame_deframe_unmask] ERROR");
        $finish;
    end

    initial begin : stimulus
        int          sel;
        int          short_len;
        bit          rs;
        bit          fin;
        logic [3:0]  opc;
        logic [63:0] big_len;

        // directed: payload extremes, empty frame, close with up to four dropped bytes, 16-bit length
        add_frame(1'b1, 1'b1, 4'h1, LEN_SHORT, 64'd4, 64'd4, 1'b1);
        add_frame(1'b0, 1'b0, 4'h9, LEN_SHORT, 64'd0, 64'd0, 1'b0);
        add_frame(1'b0, 1'b1, OPC_CLOSE, LEN_SHORT, 64'd0, 64'd0, 1'b0);
        add_frame(1'b1, 1'b1, 4'h2, LEN_16, 64'd1, 64'd1, 1'b0);

        while (rx_stream.size() < 720) begin
            sel = $urandom_range(0, 99);
            fin = 1'($urandom_range(0, 1));
            opc = 4'($urandom_range(0, 15));
            rs  = ($urandom_range(0, 3) == 0);
            if (opc == OPC_CLOSE) begin
                opc = 4'h2;
            end
            if (sel < 8) begin
                add_frame(rs, fin, OPC_CLOSE, LEN_SHORT, 64'd0, 64'd0, 1'b0);
            end else if (sel < 14) begin
                repeat ($urandom_range(1, 6)) push_beat(8'($urandom_range(0, 255)),
                                                        1'($urandom_range(0, 1)));
                resync_needed = 1'b1;
            end else if (sel < 16) begin
                add_frame(rs, fin, opc, LEN_SHORT, 64'($urandom_range(100, 125)), 64'd200,
                          1'b0);
            end else if (sel < 60) begin
                short_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
                big_len   = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, short_len))
                                                        : 64'(short_len);
                add_frame(rs, fin, opc, LEN_SHORT, 64'(short_len), big_len, 1'b0);
            end else if (sel < 66) begin
                add_frame(rs, fin, opc, LEN_16, 64'($urandom_range(0, 65535)),
                          64'($urandom_range(0, 8)), 1'b0);
            end else if (sel < 80) begin
                short_len = $urandom_range(0, 24);
                add_frame(rs, fin, opc, LEN_16, 64'(short_len), 64'(short_len), 1'b0);
            end else if (sel < 92) begin
                short_len = $urandom_range(0, 16);
                add_frame(rs, fin, opc, LEN_64, 64'(short_len), 64'(short_len), 1'b0);
            end else begin
                big_len = {$urandom, $urandom};
                add_frame(rs, fin, opc, LEN_64, big_len, 64'($urandom_range(0, 8)), 1'b0);
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (rx_stream.size() != 0 || s_valid) @(posedge aclk);
        while (frame_results_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Drove %0d beats over %0d frames and noise runs.", n_beats, n_frames);
        $display("Checked %0d payload bytes, %0d close and %0d empty-frame results, %0d errors.",
                 n_payload, n_close, n_empty, n_err);
        if (n_err == 0) begin
            $display("[websocket_frame_deframe_unmask] OK");
        end else begin
            $display("[websocket_frame_deframe_unmask] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/wsdu_pkg.sv
rtl/core/wsdu_parser.sv
rtl/core/wsdu_fifo.sv
rtl/core/wsdu_out.sv
rtl/core/websocket_frame_deframe_unmask.sv
tb/tb_top.sv
